FILE: rtl/http_chunked_body_decoder_defines.svh
// assertion macros for the chunked body decoder checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication, off while in reset
`define HCBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs during reset
`define HCBD_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hcbd_pkg.sv
// shared types and constants for the chunked body decoder
// no dependencies
`default_nettype none

package hcbd_pkg;

  localparam int LEN_BITS_DEF = 32;

  localparam logic [7:0] CHAR_NL = 8'h0A;

  // status codes on the result channel
  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_OK  = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam int TDATA_OUT_W = 16;

  // one classified request as it sits in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       blank;
    logic       hex;
    logic [3:0] hex_val;
    logic       newline;
  } hcbd_item_t;

endpackage

`default_nettype wire

FILE: rtl/hcbd_front.sv
// front part: classifies each incoming byte for the back part
// depends on hcbd_pkg
`default_nettype none

module hcbd_front
  import hcbd_pkg::*;
(
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output hcbd_item_t      item_o
);

  logic       is_dec;
  logic       is_low;
  logic       is_up;
  logic [3:0] val;

  // hex digit decode
  always_comb begin
    is_dec = (byte_i >= 8'h30) && (byte_i <= 8'h39);
    is_low = (byte_i >= 8'h61) && (byte_i <= 8'h66);
    is_up  = (byte_i >= 8'h41) && (byte_i <= 8'h46);
    if (is_dec) begin
      val = byte_i[3:0];
    end else if (is_low || is_up) begin
      val = byte_i[3:0] + 4'd9;
    end else begin
      val = 4'd0;
    end
  end

  // pack the classified request
  always_comb begin
    item_o.data    = byte_i;
    item_o.last    = last_i;
    item_o.blank   = (byte_i == 8'h20) || ((byte_i >= 8'h09) && (byte_i <= 8'h0D));
    item_o.hex     = is_dec || is_low || is_up;
    item_o.hex_val = val;
    item_o.newline = (byte_i == CHAR_NL);
  end

endmodule

`default_nettype wire

FILE: rtl/hcbd_queue.sv
// two-entry queue between the front and back parts
// depends on hcbd_pkg
`default_nettype none

module hcbd_queue
  import hcbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push_i,
  input  wire hcbd_item_t  item_i,
  output logic             full_o,
  output logic             nempty_o,
  input  wire logic        pop_i,
  output hcbd_item_t       item_o
);

  hcbd_item_t  mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full_o   = (count_r == 2'd2);
  assign nempty_o = (count_r != 2'd0);
  assign item_o   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_i) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 2'd1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hcbd_back.sv
// back part: chunk state machine and the result register
// depends on hcbd_pkg
`default_nettype none

module hcbd_back
  import hcbd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   identity_i,
  input  wire logic                   avail_i,
  input  wire hcbd_item_t             item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [TDATA_OUT_W-1:0]      out_data_o,
  output logic                        out_user_o
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_HEX, PH_TRAIL, PH_DATA, PH_DISCARD, PH_DONE_OK, PH_DONE_BAD
  } phase_t;

  phase_t                phase_r,  phase_nxt;
  logic [LEN_BITS-1:0]   size_r,   size_nxt;
  logic [LEN_BITS-1:0]   left_r,   left_nxt;
  logic                  out_valid_r;
  logic [TDATA_OUT_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  pv;
  logic [7:0]            pb;
  logic [1:0]            status;

  // take a request when the result register is free or drains now
  assign pop_o       = avail_i && (!out_valid_r || out_ready_i);
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;
  assign out_user_o  = out_user_r;

  // next state and result for the request at the head of the queue
  always_comb begin
    phase_nxt = phase_r;
    size_nxt  = size_r;
    left_nxt  = left_r;
    pv        = 1'b0;
    pb        = 8'h00;
    status    = ST_RUN;
    if (identity_i) begin
      pv = 1'b1;
      pb = item_i.data;
      if (item_i.last) begin
        status = ST_OK;
      end
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (!item_i.blank) begin
            if (item_i.hex) begin
              size_nxt  = LEN_BITS'(item_i.hex_val);
              phase_nxt = PH_HEX;
            end else begin
              phase_nxt = PH_DONE_OK;
            end
          end
        end
        PH_HEX, PH_TRAIL: begin
          if (phase_r == PH_HEX && item_i.hex) begin
            if (size_r[LEN_BITS-1 -: 4] != 4'd0) begin
              phase_nxt = PH_DONE_BAD;
            end else begin
              size_nxt = {size_r[LEN_BITS-5:0], item_i.hex_val};
            end
          end else if (item_i.blank) begin
            phase_nxt = PH_TRAIL;
          end else if (size_r == '0) begin
            phase_nxt = PH_DONE_OK;
          end else begin
            // first payload byte of the chunk
            pv        = 1'b1;
            pb        = item_i.data;
            left_nxt  = size_r - LEN_BITS'(1);
            size_nxt  = '0;
            phase_nxt = (size_r != LEN_BITS'(1)) ? PH_DATA : PH_DISCARD;
          end
        end
        PH_DATA: begin
          pv       = 1'b1;
          pb       = item_i.data;
          left_nxt = left_r - LEN_BITS'(1);
          if (left_r == LEN_BITS'(1)) begin
            phase_nxt = PH_DISCARD;
          end
        end
        PH_DISCARD: begin
          if (item_i.newline) begin
            phase_nxt = PH_LEAD;
          end
        end
        PH_DONE_OK, PH_DONE_BAD: begin
        end
        default: begin
        end
      endcase

      // outcome on the end mark, or once decided
      if (item_i.last) begin
        unique case (phase_nxt)
          PH_HEX, PH_TRAIL: status = (size_nxt == '0) ? ST_OK : ST_BAD;
          PH_DATA, PH_DONE_BAD: status = ST_BAD;
          default: status = ST_OK;
        endcase
      end else if (phase_nxt == PH_DONE_OK) begin
        status = ST_OK;
      end else if (phase_nxt == PH_DONE_BAD) begin
        status = ST_BAD;
      end
    end

    // end mark starts a new body
    if (item_i.last) begin
      phase_nxt = PH_LEAD;
      size_nxt  = '0;
      left_nxt  = '0;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      size_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_r     <= phase_nxt;
        size_r      <= size_nxt;
        left_r      <= left_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pop_o) begin
      out_data_r <= {{(TDATA_OUT_W - 10){1'b0}}, status, pb};
      out_user_r <= pv;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/http_chunked_body_decoder.sv
// top level of the chunked body decoder: config register, front, queue, back
// depends on hcbd_pkg, hcbd_front, hcbd_queue, hcbd_back
//
//   channel | direction | contents
//   in_     | slave     | tdata[7:0] body byte, tlast end of body
//   out_    | master    | tdata[7:0] payload byte, tdata[9:8] status, tuser payload valid
//   cfg_    | write     | wr_data identity mode (1 pass through, 0 chunked)
//
// one request per cycle sustained while the output is not stalled; one result per request
// the result is registered: an accepted input request passes through the queue, then the result register
// the input stalls only when the two-entry queue is full
// output stalls back up through the result register into the queue
// synchronous active-low reset; returns to chunk-size parsing with identity mode off
`default_nettype none

module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] in_byte
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [TDATA_OUT_W-1:0]      out_tdata,  // [7:0] payload_byte, [9:8] status
  output logic                        out_tuser,  // [0] payload_valid
  input  wire logic                   cfg_wr_en,
  input  wire logic                   cfg_wr_data
);

  logic        identity_r;
  hcbd_item_t  front_item;
  hcbd_item_t  head_item;
  logic        q_full;
  logic        q_nempty;
  logic        q_pop;
  logic        q_push;

  // identity mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      identity_r <= 1'b0;
    end else if (cfg_wr_en) begin
      identity_r <= cfg_wr_data;
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  hcbd_front u_front (
    .byte_i (in_tdata),
    .last_i (in_tlast),
    .item_o (front_item)
  );

  hcbd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (q_push),
    .item_i   (front_item),
    .full_o   (q_full),
    .nempty_o (q_nempty),
    .pop_i    (q_pop),
    .item_o   (head_item)
  );

  hcbd_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .identity_i  (identity_r),
    .avail_i     (q_nempty),
    .item_i      (head_item),
    .pop_o       (q_pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_tdata),
    .out_user_o  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/hcbd_checker.sv
// port-level checks for the chunked body decoder, bound to the top level
// depends on hcbd_pkg and http_chunked_body_decoder_defines.svh
`default_nettype none
`include "http_chunked_body_decoder_defines.svh"

module hcbd_checker
  import hcbd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [TDATA_OUT_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  // no result right after reset
  `HCBD_ASSERT_ALWAYS(a_reset_quiet, !rst_n, !out_tvalid, "result valid after reset")

  // a non-payload result carries a zero byte
  `HCBD_ASSERT_NOW(a_zero_byte, out_tvalid && !out_tuser, out_tdata[7:0] == 8'h00,
    "non-payload result with nonzero byte")

  // status is never the unused code and padding is zero
  `HCBD_ASSERT_NOW(a_status_code, out_tvalid,
    (out_tdata[9:8] == ST_RUN || out_tdata[9:8] == ST_OK || out_tdata[9:8] == ST_BAD) &&
    out_tdata[TDATA_OUT_W-1:10] == '0, "bad status code or padding")

  // a stalled result holds
  `HCBD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
